// ===== rtl/frmavg_pkg.sv =====
// shared types and constants for the frame rate moving average block
`timescale 1ns / 1ps

package frmavg_pkg;

    // fixed field widths
    localparam int TS_W     = 32;
    localparam int SAMPLE_W = 10;
    localparam int AVG_W    = 18;
    localparam int FRAC_W   = 8;

    // milliseconds per second, numerator of the instantaneous rate
    localparam int unsigned RATE_NUMERATOR = 1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE_DIV,
        ST_WRITE,
        ST_SUM,
        ST_MEAN_DIV,
        ST_DONE
    } frmavg_state_t;

endpackage

// ===== rtl/frmavg_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module frmavg_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 10,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/frame_rate_moving_average_top.sv =====
// frame rate moving average: rate from timestamp delta, mean over a sample ring
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// s_        in         s_valid / s_ready   s_timestamp_ms[31:0]
// m_        out        m_valid / m_ready   m_average_rate_q8[17:0], m_rate_valid
//
// one transaction, from accept to result register, runs on one shared adder/subtractor:
// a 10 step restoring divide for 1000 / elapsed, a sweep over the ring ram at one
// read a cycle, then a SUM_W + 8 step divide for the mean; a delta above 1000 skips
// the rate divide, and a zero delta skips the ring write, the sweep and both divides
// on its way to the result register
// s_ready is high only while the sequencer is idle; a finished result waits in the
// output register and the next transaction may be accepted meanwhile, while a result
// that finds the output register still full holds the sequencer in its last step
// synchronous active low reset clears the previous timestamp, ring pointer and fill
// count; never written ring entries are never read, so no clearing pass is needed

module frame_rate_moving_average_top
    import frmavg_pkg::*;
#(
    parameter int WINDOW_SIZE = 10
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [TS_W-1:0]   s_timestamp_ms,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [AVG_W-1:0]  m_average_rate_q8,
    output logic              m_rate_valid
);

    // derived sizes
    localparam int ADDR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W  = $clog2(RATE_NUMERATOR * WINDOW_SIZE + 1);
    localparam int DIVD_W = SUM_W + FRAC_W;          // dividend of the mean divide
    localparam int REM_W  = SAMPLE_W + 1;            // partial remainder, divisor < 2^10
    localparam int ALU_W  = SUM_W + 2;               // shared adder width
    localparam int STEP_W = $clog2(DIVD_W + 1);

    localparam logic [TS_W-1:0]     RATE_LIMIT = TS_W'(RATE_NUMERATOR);
    localparam logic [SAMPLE_W-1:0] RATE_NUM   = SAMPLE_W'(RATE_NUMERATOR);
    localparam logic [ADDR_W-1:0]   LAST_POS   = ADDR_W'(WINDOW_SIZE - 1);
    localparam logic [CNT_W-1:0]    FULL_CNT   = CNT_W'(WINDOW_SIZE);

    // sequencer and control state
    frmavg_state_t       state_reg, state_next;
    logic [TS_W-1:0]     prev_ts_reg, prev_ts_next;
    logic [ADDR_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]    filled_reg, filled_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                m_valid_reg, m_valid_next;

    // datapath registers
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [DIVD_W-1:0]   quo_reg, quo_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [SAMPLE_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                zero_reg, zero_next;
    logic [AVG_W-1:0]    avg_reg, avg_next;
    logic                rate_valid_reg, rate_valid_next;

    // shared adder / subtractor
    logic [ALU_W-1:0]    alu_a, alu_b;
    logic                alu_sub;
    logic [ALU_W:0]      alu_res;
    logic                no_borrow;

    logic [TS_W-1:0]     elapsed;
    logic [REM_W-1:0]    div_shift;

    // ring ram ports
    logic                ram_wr_en;
    logic [SAMPLE_W-1:0] ram_rd_data;

    frmavg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_SIZE)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (quo_reg[SAMPLE_W-1:0]),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign elapsed   = s_timestamp_ms - prev_ts_reg;
    // next partial remainder before the trial subtract
    assign div_shift = {rem_reg[REM_W-2:0], quo_reg[DIVD_W-1]};

    assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (ALU_W + 1)'(alu_sub);
    // carry out of a subtract means the divisor fits
    assign no_borrow = alu_res[ALU_W];

    // operand selection for the shared unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_RATE_DIV, ST_MEAN_DIV: begin
                alu_a   = {{(ALU_W - REM_W){1'b0}}, div_shift};
                alu_b   = {{(ALU_W - SAMPLE_W){1'b0}}, div_reg};
                alu_sub = 1'b1;
            end
            ST_SUM: begin
                alu_a   = {{(ALU_W - SUM_W){1'b0}}, acc_reg};
                alu_b   = {{(ALU_W - SAMPLE_W){1'b0}}, ram_rd_data};
                alu_sub = 1'b0;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // sequencer: next state and datapath control
    always_comb begin
        state_next      = state_reg;
        prev_ts_next    = prev_ts_reg;
        wp_next         = wp_reg;
        filled_next     = filled_reg;
        idx_next        = idx_reg;
        rd_pend_next    = rd_pend_reg;
        m_valid_next    = m_valid_reg;
        acc_next        = acc_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        zero_next       = zero_reg;
        avg_next        = avg_reg;
        rate_valid_next = rate_valid_reg;
        ram_wr_en       = 1'b0;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    prev_ts_next = s_timestamp_ms;
                    zero_next    = (elapsed == '0);
                    rem_next     = '0;
                    div_next     = elapsed[SAMPLE_W-1:0];
                    step_next    = STEP_W'(SAMPLE_W);
                    if (elapsed == '0) begin
                        // no sample, ring left alone
                        state_next = ST_DONE;
                    end else if (elapsed > RATE_LIMIT) begin
                        // rate rounds down to zero, skip the divide
                        quo_next   = '0;
                        state_next = ST_WRITE;
                    end else begin
                        quo_next   = {RATE_NUM, {(DIVD_W - SAMPLE_W){1'b0}}};
                        state_next = ST_RATE_DIV;
                    end
                end
            end

            ST_RATE_DIV, ST_MEAN_DIV: begin
                rem_next  = no_borrow ? alu_res[REM_W-1:0] : div_shift;
                quo_next  = {quo_reg[DIVD_W-2:0], no_borrow};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    state_next = (state_reg == ST_RATE_DIV) ? ST_WRITE : ST_DONE;
                end
            end

            ST_WRITE: begin
                ram_wr_en    = 1'b1;
                wp_next      = (wp_reg == LAST_POS) ? '0 : wp_reg + ADDR_W'(1);
                if (filled_reg != FULL_CNT) begin
                    filled_next = filled_reg + CNT_W'(1);
                end
                idx_next     = '0;
                rd_pend_next = 1'b0;
                acc_next     = '0;
                state_next   = ST_SUM;
            end

            ST_SUM: begin
                // one read issued and one sample added per cycle
                if (rd_pend_reg) begin
                    acc_next = alu_res[SUM_W-1:0];
                end
                if (idx_reg != filled_reg) begin
                    idx_next     = idx_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg) begin
                        quo_next   = {acc_reg, {FRAC_W{1'b0}}};
                        rem_next   = '0;
                        div_next   = {{(SAMPLE_W - CNT_W){1'b0}}, filled_reg};
                        step_next  = STEP_W'(DIVD_W);
                        state_next = ST_MEAN_DIV;
                    end
                end
            end

            ST_DONE: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    avg_next        = zero_reg ? '0 : quo_reg[AVG_W-1:0];
                    rate_valid_next = !zero_reg;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            prev_ts_reg <= '0;
            wp_reg      <= '0;
            filled_reg  <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prev_ts_reg <= prev_ts_next;
            wp_reg      <= wp_next;
            filled_reg  <= filled_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        acc_reg        <= acc_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        step_reg       <= step_next;
        zero_reg       <= zero_next;
        avg_reg        <= avg_next;
        rate_valid_reg <= rate_valid_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_average_rate_q8 = avg_reg;
    assign m_rate_valid      = rate_valid_reg;

`ifndef SYNTHESIS
    // ring pointer stays inside the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= LAST_POS)
        else $error("ring pointer outside window");

    // fill count never shrinks and never passes the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (filled_reg <= FULL_CNT) ##1 (filled_reg >= $past(filled_reg)))
        else $error("fill count out of order");

    // a valid rate needs at least one stored sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rate_valid) |-> (filled_reg != '0))
        else $error("valid rate with empty ring");

    // a skipped sample reports zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_rate_valid) |-> (m_average_rate_q8 == '0))
        else $error("nonzero mean on zero delta");

    // mean cannot exceed the largest possible sample, RATE_NUMERATOR in Q8
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_average_rate_q8 <= AVG_W'(RATE_NUMERATOR << FRAC_W)))
        else $error("mean above maximum rate");
`endif

endmodule
